>>> rtl/dqz_pkg.sv
// Shared types, codes and rounding helpers for the tensor element dequantizer.
`default_nettype none
package dqz_pkg;

	localparam logic [3:0] TYPE_INT8   = 4'd0;
	localparam logic [3:0] TYPE_UINT8  = 4'd1;
	localparam logic [3:0] TYPE_INT16  = 4'd2;
	localparam logic [3:0] TYPE_UINT16 = 4'd3;
	localparam logic [3:0] TYPE_INT32  = 4'd4;
	localparam logic [3:0] TYPE_UINT32 = 4'd5;
	localparam logic [3:0] TYPE_INT64  = 4'd6;
	localparam logic [3:0] TYPE_UINT64 = 4'd7;
	localparam logic [3:0] TYPE_FP16   = 4'd8;
	localparam logic [3:0] TYPE_FP32   = 4'd9;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_RANGE  = 3'd1;
	localparam logic [2:0] ST_FQUANT = 3'd2;
	localparam logic [2:0] ST_BADQ   = 3'd3;
	localparam logic [2:0] ST_NONFIN = 3'd4;

	localparam logic [2:0] CFG_TYPE  = 3'd0;
	localparam logic [2:0] CFG_BYTES = 3'd1;
	localparam logic [2:0] CFG_QUANT = 3'd2;
	localparam logic [2:0] CFG_SCALE = 3'd3;
	localparam logic [2:0] CFG_ZERO  = 3'd4;

	// travels with each element down the pipe
	typedef struct packed {
		logic        vld;
		logic [2:0]  st;
		logic        fpath;
		logic [31:0] fval;
	} dqz_ctrl_t;

	// position of the highest set bit, 0 for zero
	function automatic logic [6:0] lead_pos(input logic [65:0] x);
		logic [6:0] pos;
		pos = '0;
		for (int i = 0; i < 66; i++) begin
			if (x[i]) pos = 7'(i);
		end
		return pos;
	endfunction

	// right shift with round to nearest, ties to even
	function automatic logic [65:0] rne_shr(input logic [65:0] x, input logic [6:0] sh);
		logic [65:0] q;
		logic [65:0] rem;
		logic [65:0] half;
		q    = x >> sh;
		rem  = x & ~({66{1'b1}} << sh);
		half = (sh == 7'd0) ? '0 : (66'd1 << (sh - 7'd1));
		if (sh != 7'd0 && (rem > half || (rem == half && q[0]))) q = q + 66'd1;
		return q;
	endfunction

endpackage
`default_nettype wire

>>> rtl/dqz_decode.sv
// First stage: range and type checks, half widening, integer sign and magnitude.
`default_nettype none
module dqz_decode
	import dqz_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        elem_valid,
	input  wire logic [31:0] element_index,
	input  wire logic [63:0] raw_element,
	input  wire logic [3:0]  element_type,
	input  wire logic [31:0] tensor_byte_count,
	input  wire logic        quantized_flag,
	input  wire logic [31:0] scale_bits,
	input  wire logic [31:0] zero_offset,
	output dqz_ctrl_t        ctrl_s1,
	output logic [63:0]      vmag_s1,
	output logic             vneg_s1,
	output logic [31:0]      zmag_s1,
	output logic             zneg_s1
);

	function automatic logic [31:0] half_widen(input logic [15:0] h);
		logic [31:0] sign;
		logic [4:0]  ex;
		logic [9:0]  man;
		logic [6:0]  q;
		logic [10:0] nm;
		logic [7:0]  ne;
		sign = {h[15], 31'd0};
		ex   = h[14:10];
		man  = h[9:0];
		q    = lead_pos({56'd0, man});
		nm   = {1'b0, man} << (7'd10 - q);
		ne   = 8'd103 + 8'(q);
		if (ex == 5'd0) begin
			if (man == 10'd0) return sign;
			return sign | {1'b0, ne, nm[9:0], 13'd0};
		end
		if (ex == 5'h1f) return sign | 32'h7f80_0000 | {9'd0, man, 13'd0};
		return sign | {1'b0, 8'(ex) + 8'd112, man, 13'd0};
	endfunction

	logic        sz_ok;
	logic [1:0]  sz_l;
	logic        sgn;
	logic [63:0] sx;
	logic        neg;
	logic        range_bad;
	logic        scale_bad;
	dqz_ctrl_t   ctrl_d;

	always_comb begin
		sz_ok = 1'b1;
		sz_l  = 2'd0;
		unique case (element_type)
			TYPE_INT8, TYPE_UINT8:               sz_l = 2'd0;
			TYPE_INT16, TYPE_UINT16, TYPE_FP16:  sz_l = 2'd1;
			TYPE_INT32, TYPE_UINT32, TYPE_FP32:  sz_l = 2'd2;
			TYPE_INT64, TYPE_UINT64:             sz_l = 2'd3;
			default:                             sz_ok = 1'b0;
		endcase
		sgn = ~element_type[0];
		unique case (sz_l)
			2'd0: sx = {{56{raw_element[7] & sgn}}, raw_element[7:0]};
			2'd1: sx = {{48{raw_element[15] & sgn}}, raw_element[15:0]};
			2'd2: sx = {{32{raw_element[31] & sgn}}, raw_element[31:0]};
			default: sx = raw_element;
		endcase
		neg = sgn & sx[63];

		range_bad = !sz_ok || (element_index >= (tensor_byte_count >> sz_l)) ||
			((tensor_byte_count & ~({32{1'b1}} << sz_l)) != 32'd0);
		scale_bad = !quantized_flag || scale_bits[31] ||
			(scale_bits[30:23] == 8'hff) || (scale_bits[30:0] == 31'd0);

		ctrl_d.vld   = elem_valid;
		ctrl_d.st    = ST_OK;
		ctrl_d.fpath = 1'b0;
		ctrl_d.fval  = '0;
		if (range_bad) begin
			ctrl_d.st = ST_RANGE;
		end else if (element_type[3]) begin
			if (quantized_flag) begin
				ctrl_d.st = ST_FQUANT;
			end else begin
				ctrl_d.fpath = 1'b1;
				ctrl_d.fval  = (element_type == TYPE_FP16) ?
					half_widen(raw_element[15:0]) : raw_element[31:0];
			end
		end else if (scale_bad) begin
			ctrl_d.st = ST_BADQ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (en) begin
			ctrl_s1 <= ctrl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vmag_s1 <= neg ? (64'd0 - sx) : sx;
			vneg_s1 <= neg;
			zneg_s1 <= zero_offset[31];
			zmag_s1 <= zero_offset[31] ? (32'd0 - zero_offset) : zero_offset;
		end
	end

endmodule
`default_nettype wire

>>> rtl/dqz_i2f.sv
// Integer to float rounding of element and zero point, exact difference, rounding of it.
`default_nettype none
module dqz_i2f
	import dqz_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire dqz_ctrl_t   ctrl_s1,
	input  wire logic [63:0] vmag_s1,
	input  wire logic        vneg_s1,
	input  wire logic [31:0] zmag_s1,
	input  wire logic        zneg_s1,
	output dqz_ctrl_t        ctrl_s7,
	output logic [23:0]      md_s7,
	output logic [7:0]       ed_s7,
	output logic             dneg_s7,
	output logic             dzero_s7
);

	dqz_ctrl_t   ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5, ctrl_s6;
	logic [63:0] vmag_s2;
	logic [31:0] zmag_s2;
	logic [6:0]  pv_s2, pz_s2;
	logic        vneg_s2, zneg_s2, vneg_s3, zneg_s3;
	logic [64:0] sint_s3;
	logic [32:0] zint_s3;
	logic [66:0] d_s4;
	logic [65:0] dmag_s5, dmag_s6;
	logic        dneg_s5, dneg_s6;
	logic [6:0]  pd_s6;

	logic [65:0] mv, mz, md;
	logic [64:0] sint_d;
	logic [32:0] zint_d;
	logic [66:0] a_d, b_d;
	logic [23:0] md_d;
	logic [7:0]  ed_d;

	always_comb begin
		mv = rne_shr({2'b0, vmag_s2}, pv_s2 - 7'd23);
		mz = rne_shr({34'b0, zmag_s2}, pz_s2 - 7'd23);
		// the float values are integers: keep them as exact integers
		sint_d = (pv_s2 <= 7'd23) ? {1'b0, vmag_s2} : (mv[64:0] << (pv_s2 - 7'd23));
		zint_d = (pz_s2 <= 7'd23) ? {1'b0, zmag_s2} : (mz[32:0] << (pz_s2 - 7'd23));
		a_d = vneg_s3 ? (67'd0 - {2'b0, sint_s3}) : {2'b0, sint_s3};
		b_d = zneg_s3 ? (67'd0 - {34'b0, zint_s3}) : {34'b0, zint_s3};
		md  = rne_shr(dmag_s6, pd_s6 - 7'd23);
		if (pd_s6 <= 7'd23) begin
			md_d = 24'(dmag_s6 << (7'd23 - pd_s6));
			ed_d = 8'(pd_s6) + 8'd127;
		end else if (md[24]) begin
			md_d = md[24:1];
			ed_d = 8'(pd_s6) + 8'd128;
		end else begin
			md_d = md[23:0];
			ed_d = 8'(pd_s6) + 8'd127;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
			ctrl_s5 <= '0;
			ctrl_s6 <= '0;
			ctrl_s7 <= '0;
		end else if (en) begin
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
			ctrl_s5 <= ctrl_s4;
			ctrl_s6 <= ctrl_s5;
			ctrl_s7 <= ctrl_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vmag_s2  <= vmag_s1;
			zmag_s2  <= zmag_s1;
			vneg_s2  <= vneg_s1;
			zneg_s2  <= zneg_s1;
			pv_s2    <= lead_pos({2'b0, vmag_s1});
			pz_s2    <= lead_pos({34'b0, zmag_s1});
			sint_s3  <= sint_d;
			zint_s3  <= zint_d;
			vneg_s3  <= vneg_s2;
			zneg_s3  <= zneg_s2;
			d_s4     <= a_d - b_d;
			dneg_s5  <= d_s4[66];
			dmag_s5  <= d_s4[66] ? 66'(67'd0 - d_s4) : d_s4[65:0];
			dneg_s6  <= dneg_s5;
			dmag_s6  <= dmag_s5;
			pd_s6    <= lead_pos(dmag_s5);
			md_s7    <= md_d;
			ed_s7    <= ed_d;
			dneg_s7  <= dneg_s6;
			dzero_s7 <= (dmag_s6 == 66'd0);
		end
	end

endmodule
`default_nettype wire

>>> rtl/dqz_fmul.sv
// Float multiply by the scale with subnormal output, overflow check, final result select.
`default_nettype none
module dqz_fmul
	import dqz_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire dqz_ctrl_t   ctrl_s7,
	input  wire logic [23:0] md_s7,
	input  wire logic [7:0]  ed_s7,
	input  wire logic        dneg_s7,
	input  wire logic        dzero_s7,
	input  wire logic [31:0] scale_bits,
	output dqz_ctrl_t        ctrl_s10
);

	dqz_ctrl_t   ctrl_s8, ctrl_s9, ctrl_d;
	logic [47:0] p_s8, p_s9;
	logic [8:0]  esum_s8;
	logic        sign_s8, sign_s9, zero_s8;
	logic [6:0]  sh_s9;
	logic [8:0]  ebase_s9;

	logic [23:0]        ms;
	logic [7:0]         esf;
	logic [5:0]         lpos;
	logic signed [10:0] be;
	logic [6:0]         sh_d;
	logic [8:0]         ebase_d;
	logic [65:0]        m;
	logic [33:0]        rb;

	always_comb begin
		ms  = {(scale_bits[30:23] != 8'd0), scale_bits[22:0]};
		esf = (scale_bits[30:23] == 8'd0) ? 8'd1 : scale_bits[30:23];

		lpos = 6'(lead_pos({18'b0, p_s8}));
		be   = $signed({5'b0, lpos}) + $signed({2'b0, esum_s8}) - 11'sd173;
		if (zero_s8) begin
			sh_d    = '0;
			ebase_d = '0;
		end else if (be <= 11'sd0) begin
			// subnormal result: extra right shift down to exponent one
			sh_d    = 7'(lpos - 6'd23) + 7'(11'sd1 - be);
			ebase_d = '0;
		end else begin
			sh_d    = 7'(lpos - 6'd23);
			ebase_d = 9'(be - 11'sd1);
		end

		// rounding carry walks into the exponent field
		m  = rne_shr({18'b0, p_s9}, sh_s9);
		rb = {2'b0, ebase_s9, 23'd0} + m[33:0];

		ctrl_d = ctrl_s9;
		if (ctrl_s9.st != ST_OK) begin
			ctrl_d.fval = '0;
		end else if (!ctrl_s9.fpath) begin
			if (rb[33:23] >= 11'd255) begin
				ctrl_d.st   = ST_NONFIN;
				ctrl_d.fval = '0;
			end else begin
				ctrl_d.fval = {sign_s9, rb[30:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s8  <= '0;
			ctrl_s9  <= '0;
			ctrl_s10 <= '0;
		end else if (en) begin
			ctrl_s8  <= ctrl_s7;
			ctrl_s9  <= ctrl_s8;
			ctrl_s10 <= ctrl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s8     <= md_s7 * ms;
			esum_s8  <= {1'b0, ed_s7} + {1'b0, esf};
			sign_s8  <= dneg_s7 & ~dzero_s7;
			zero_s8  <= dzero_s7;
			p_s9     <= p_s8;
			sign_s9  <= sign_s8;
			sh_s9    <= sh_d;
			ebase_s9 <= ebase_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/tensor_element_dequantizer.sv
// Top level: configuration registers, pipeline flow control and stage hookup.
`default_nettype none
// Accepts one element per cycle while not stalled and returns its float32 value and status;
// the pipeline has ten register stages and the last stage is the output register.
// A stall on the result side freezes every stage, and the input side is stalled in the
// same cycle. Integer elements are rounded to float32, the zero point is subtracted and
// the difference is rounded, then multiplied by the scale with full subnormal support;
// the 24 by 24 bit mantissa multiply sits alone in its stage. Configuration writes are
// taken at any time and must be made only while no element is in flight.
module tensor_element_dequantizer
	import dqz_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        elem_valid,
	output logic             elem_stall,
	input  wire logic [31:0] element_index,
	input  wire logic [63:0] raw_element,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [31:0]      float_value,
	output logic [2:0]       status
);

	logic [3:0]  element_type_q;
	logic [31:0] tensor_byte_count_q;
	logic        quantized_flag_q;
	logic [31:0] scale_bits_q;
	logic [31:0] zero_offset_q;

	logic        en;
	dqz_ctrl_t   ctrl_s1, ctrl_s7, ctrl_s10;
	logic [63:0] vmag_s1;
	logic        vneg_s1, zneg_s1;
	logic [31:0] zmag_s1;
	logic [23:0] md_s7;
	logic [7:0]  ed_s7;
	logic        dneg_s7, dzero_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_type_q      <= '0;
			tensor_byte_count_q <= '0;
			quantized_flag_q    <= 1'b0;
			scale_bits_q        <= '0;
			zero_offset_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TYPE:  element_type_q      <= cfg_data[3:0];
				CFG_BYTES: tensor_byte_count_q <= cfg_data;
				CFG_QUANT: quantized_flag_q    <= cfg_data[0];
				CFG_SCALE: scale_bits_q        <= cfg_data;
				CFG_ZERO:  zero_offset_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en           = !(ctrl_s10.vld && result_stall);
	assign elem_stall   = !en;
	assign result_valid = ctrl_s10.vld;
	assign float_value  = ctrl_s10.fval;
	assign status       = ctrl_s10.st;

	dqz_decode u_decode (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (en),
		.elem_valid        (elem_valid),
		.element_index     (element_index),
		.raw_element       (raw_element),
		.element_type      (element_type_q),
		.tensor_byte_count (tensor_byte_count_q),
		.quantized_flag    (quantized_flag_q),
		.scale_bits        (scale_bits_q),
		.zero_offset       (zero_offset_q),
		.ctrl_s1           (ctrl_s1),
		.vmag_s1           (vmag_s1),
		.vneg_s1           (vneg_s1),
		.zmag_s1           (zmag_s1),
		.zneg_s1           (zneg_s1)
	);

	dqz_i2f u_i2f (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctrl_s1  (ctrl_s1),
		.vmag_s1  (vmag_s1),
		.vneg_s1  (vneg_s1),
		.zmag_s1  (zmag_s1),
		.zneg_s1  (zneg_s1),
		.ctrl_s7  (ctrl_s7),
		.md_s7    (md_s7),
		.ed_s7    (ed_s7),
		.dneg_s7  (dneg_s7),
		.dzero_s7 (dzero_s7)
	);

	dqz_fmul u_fmul (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ctrl_s7    (ctrl_s7),
		.md_s7      (md_s7),
		.ed_s7      (ed_s7),
		.dneg_s7    (dneg_s7),
		.dzero_s7   (dzero_s7),
		.scale_bits (scale_bits_q),
		.ctrl_s10   (ctrl_s10)
	);

endmodule
`default_nettype wire

>>> tb/sv/tensor_element_dequantizer_tb.sv
// Self-checking testbench for the tensor element dequantizer: directed table, then random.
module tensor_element_dequantizer_tb;
	import dqz_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 14;
	localparam int HOLD_CYCLES    = 400;

	typedef struct packed {
		logic [31:0] val;
		logic [2:0]  st;
	} deq_res_t;

	typedef struct packed {
		logic [3:0]  ty;
		logic [31:0] nbytes;
		logic        quant;
		logic [31:0] scale;
		logic [31:0] zero;
		logic [31:0] idx;
		logic [63:0] raw;
		logic        typed;
		logic [31:0] val;
		logic [2:0]  st;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        elem_valid;
	logic        elem_stall;
	logic [31:0] element_index;
	logic [63:0] raw_element;
	logic        result_valid;
	logic        result_stall;
	logic [31:0] float_value;
	logic [2:0]  status;

	// shadow of the configuration registers
	logic [3:0]  sh_type;
	logic [31:0] sh_bytes;
	logic        sh_quant;
	logic [31:0] sh_scale;
	logic [31:0] sh_zero;

	deq_res_t    pending_q[$];
	dir_row_t    dir_tab[$];
	int          fail_cnt;
	int          idle_pct;
	int          stall_pct;
	bit          hold_req;
	int          hold_left;
	int          quiet_cycles;

	tensor_element_dequantizer i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.elem_valid(elem_valid), .elem_stall(elem_stall),
		.element_index(element_index), .raw_element(raw_element),
		.result_valid(result_valid), .result_stall(result_stall),
		.float_value(float_value), .status(status)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// ---------------- float32 arithmetic, round to nearest even ----------------

	// value = mag * 2^ex, rounded to float32 with subnormals and overflow to inf
	function automatic logic [31:0] f32_round(input bit sgn, input logic [255:0] mag,
			input int ex);
		int p;
		int q;
		int sh;
		logic [255:0] m;
		logic [255:0] rem;
		logic [255:0] half;
		if (mag == '0) return {sgn, 31'd0};
		p = 0;
		for (int i = 0; i < 256; i++) if (mag[i]) p = i;
		q = p + ex - 23;
		if (q < -149) q = -149;
		sh = q - ex;
		if (sh <= 0) begin
			m = mag << (-sh);
		end else begin
			m    = mag >> sh;
			rem  = mag & ~({256{1'b1}} << sh);
			half = 256'd1 << (sh - 1);
			if (rem > half || (rem == half && m[0])) m = m + 256'd1;
		end
		if (m[24]) begin
			m = m >> 1;
			q++;
		end
		if (!m[23]) return {sgn, 8'd0, m[22:0]};
		if (q + 150 >= 255) return {sgn, 8'hff, 23'd0};
		return {sgn, 8'(q + 150), m[22:0]};
	endfunction

	function automatic void f32_split(input logic [31:0] f, output logic [23:0] m,
			output int e);
		if (f[30:23] == 8'd0) begin
			m = {1'b0, f[22:0]};
			e = -149;
		end else begin
			m = {1'b1, f[22:0]};
			e = int'(f[30:23]) - 150;
		end
	endfunction

	function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
		logic [23:0]  ma;
		logic [23:0]  mb;
		int           ea;
		int           eb;
		int           mn;
		logic [255:0] wa;
		logic [255:0] wb;
		f32_split(a, ma, ea);
		f32_split(b, mb, eb);
		mn = (ea < eb) ? ea : eb;
		wa = 256'(ma) << (ea - mn);
		wb = 256'(mb) << (eb - mn);
		if (a[31] == b[31]) return f32_round(a[31], wa + wb, mn);
		if (wa == wb) return 32'd0;
		if (wa > wb) return f32_round(a[31], wa - wb, mn);
		return f32_round(b[31], wb - wa, mn);
	endfunction

	function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
		logic [23:0] ma;
		logic [23:0] mb;
		int          ea;
		int          eb;
		f32_split(a, ma, ea);
		f32_split(b, mb, eb);
		return f32_round(a[31] ^ b[31], 256'(ma) * 256'(mb), ea + eb);
	endfunction

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [7:0] e;
		logic [9:0] m;
		if (h[14:10] == 5'd0) begin
			if (h[9:0] == 10'd0) return {h[15], 31'd0};
			// normalize the subnormal
			e = 8'd113;
			m = h[9:0];
			while (!m[9]) begin
				m = m << 1;
				e--;
			end
			return {h[15], e - 8'd1, m[8:0], 14'd0};
		end
		if (h[14:10] == 5'h1f) return {h[15], 8'hff, h[9:0], 13'd0};
		return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
	endfunction

	function automatic int bytes_per_elem(input logic [3:0] ty);
		case (ty)
			TYPE_INT8, TYPE_UINT8:               return 1;
			TYPE_INT16, TYPE_UINT16, TYPE_FP16:  return 2;
			TYPE_INT32, TYPE_UINT32, TYPE_FP32:  return 4;
			TYPE_INT64, TYPE_UINT64:             return 8;
			default:                             return 0;
		endcase
	endfunction

	function automatic deq_res_t dequantize(input logic [31:0] idx, input logic [63:0] raw);
		deq_res_t    r;
		int          es;
		int          nbits;
		logic [63:0] v;
		logic [63:0] zmag;
		bit          neg;
		logic [31:0] sf;
		logic [31:0] zf;
		logic [31:0] prod;
		r  = '{val: 32'd0, st: ST_OK};
		es = bytes_per_elem(sh_type);
		if (es == 0 || {32'd0, idx} >= 64'(sh_bytes / es) || sh_bytes % es != 0) begin
			r.st = ST_RANGE;
		end else if (sh_type == TYPE_FP16 || sh_type == TYPE_FP32) begin
			if (sh_quant) r.st = ST_FQUANT;
			else if (sh_type == TYPE_FP16) r.val = half_to_single(raw[15:0]);
			else r.val = raw[31:0];
		end else if (!sh_quant || sh_scale[31] || sh_scale[30:23] == 8'hff ||
				sh_scale[30:0] == 31'd0) begin
			r.st = ST_BADQ;
		end else begin
			nbits = es * 8;
			v     = (nbits == 64) ? raw : raw & ((64'd1 << nbits) - 64'd1);
			neg   = !sh_type[0] && v[nbits - 1];
			if (neg) begin
				if (nbits < 64) v = v | ~((64'd1 << nbits) - 64'd1);
				v = 64'd0 - v;
			end
			zmag = sh_zero[31] ? {32'd0, 32'd0 - sh_zero} : {32'd0, sh_zero};
			sf   = f32_round(neg, 256'(v), 0);
			zf   = f32_round(sh_zero[31], 256'(zmag), 0);
			prod = f32_mul(f32_add(sf, {~zf[31], zf[30:0]}), sh_scale);
			if (prod[30:23] == 8'hff) r.st = ST_NONFIN;
			else r.val = prod;
		end
		return r;
	endfunction

	// ---------------- driving ----------------

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_TYPE:  sh_type  = data[3:0];
			CFG_BYTES: sh_bytes = data;
			CFG_QUANT: sh_quant = data[0];
			CFG_SCALE: sh_scale = data;
			CFG_ZERO:  sh_zero  = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// sender pause: no element offered until every result is back
	task automatic drain();
		@(negedge clk);
		elem_valid <= 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_tensor(input logic [3:0] ty, input logic [31:0] nbytes,
			input logic quant, input logic [31:0] scale, input logic [31:0] zero);
		drain();
		write_reg(CFG_TYPE, {28'd0, ty});
		write_reg(CFG_BYTES, nbytes);
		write_reg(CFG_QUANT, {31'd0, quant});
		write_reg(CFG_SCALE, scale);
		write_reg(CFG_ZERO, zero);
	endtask

	task automatic send_elem(input logic [31:0] idx, input logic [63:0] raw,
			input bit typed, input deq_res_t typed_res);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			elem_valid <= 1'b0;
		end
		@(negedge clk);
		elem_valid    <= 1'b1;
		element_index <= idx;
		raw_element   <= raw;
		@(posedge clk);
		while (elem_stall) @(posedge clk);
		pending_q.push_back(typed ? typed_res : dequantize(idx, raw));
	endtask

	// ---------------- result side ----------------

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		deq_res_t want;
		if (result_valid && !result_stall) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result transfer: float_value %h status %0d",
					float_value, status);
				fail_cnt++;
			end else begin
				want = pending_q.pop_front();
				if (float_value !== want.val) begin
					$error("float_value: expected %h, got %h", want.val, float_value);
					fail_cnt++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((elem_valid && !elem_stall) || (result_valid && !result_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------- random configuration ----------------

	task automatic random_tensor();
		logic [3:0]  ty;
		logic [31:0] nbytes;
		logic        quant;
		logic [31:0] scale;
		logic [31:0] zero;
		int          es;
		ty = ($urandom_range(9) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
		es = bytes_per_elem(ty);
		if (es != 0 && $urandom_range(99) < 85) nbytes = es * $urandom_range(1, 4096);
		else nbytes = $urandom;
		if (ty >= TYPE_FP16) quant = ($urandom_range(99) < 20);
		else quant = ($urandom_range(99) < 90);
		case ($urandom_range(9))
			0, 1:    scale = {1'b0, 8'd0, 23'($urandom)};
			2:       scale = $urandom;
			default: scale = {1'b0, 8'($urandom_range(90, 150)), 23'($urandom)};
		endcase
		zero = ($urandom_range(1)) ? $urandom : 32'($signed($urandom_range(0, 512)) - 256);
		set_tensor(ty, nbytes, quant, scale, zero);
	endtask

	task automatic random_elems(input int n);
		int          es;
		logic [31:0] idx;
		logic [63:0] raw;
		for (int k = 0; k < n; k++) begin
			es = bytes_per_elem(sh_type);
			if (es != 0 && sh_bytes >= es && $urandom_range(99) < 85)
				idx = $urandom_range(0, sh_bytes / es - 1);
			else
				idx = $urandom;
			raw = {$urandom, $urandom};
			if ($urandom_range(7) == 0) raw = raw & 64'h0000_0000_0000_83ff;
			send_elem(idx, raw, 1'b0, '0);
		end
	endtask

	initial begin
		int idle_tab[4];
		int stall_tab[4];
		fail_cnt      = 0;
		hold_req      = 1'b0;
		hold_left     = 0;
		quiet_cycles  = 0;
		idle_pct      = 0;
		stall_pct     = 0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_TYPE;
		cfg_data      = 32'd0;
		elem_valid    = 1'b0;
		element_index = 32'd0;
		raw_element   = 64'd0;
		result_stall  = 1'b0;
		sh_type       = TYPE_INT8;
		sh_bytes      = 32'd0;
		sh_quant      = 1'b0;
		sh_scale      = 32'd0;
		sh_zero       = 32'd0;
		idle_tab  = '{0, 74, 0, 27};
		stall_tab = '{0, 0, 74, 27};

		// type, bytes, quant, scale, zero, index, raw, typed, value, status
		dir_tab.push_back('{TYPE_INT8, 32'd16, 1'b1, 32'h3f800000, 32'd0, 32'd15,
			64'hffff_ffff_ffff_ffff, 1'b1, 32'hbf800000, ST_OK});
		dir_tab.push_back('{TYPE_INT8, 32'd16, 1'b1, 32'h3f800000, 32'd0, 32'd16,
			64'd1, 1'b1, 32'd0, ST_RANGE});
		dir_tab.push_back('{4'd10, 32'd64, 1'b0, 32'h3f800000, 32'd0, 32'd0,
			64'd1, 1'b1, 32'd0, ST_RANGE});
		dir_tab.push_back('{4'd15, 32'hffffffff, 1'b1, 32'hffffffff, 32'h80000000, 32'd0,
			64'd1, 1'b1, 32'd0, ST_RANGE});
		dir_tab.push_back('{TYPE_INT16, 32'd7, 1'b1, 32'h3f800000, 32'd0, 32'd0,
			64'd1, 1'b1, 32'd0, ST_RANGE});
		dir_tab.push_back('{TYPE_UINT8, 32'hffffffff, 1'b1, 32'h3f800000, 32'd0, 32'hffffffff,
			64'd1, 1'b1, 32'd0, ST_RANGE});
		dir_tab.push_back('{TYPE_FP16, 32'd8, 1'b1, 32'h3f800000, 32'd0, 32'd0,
			64'h3c00, 1'b1, 32'd0, ST_FQUANT});
		dir_tab.push_back('{TYPE_FP32, 32'd8, 1'b1, 32'h3f800000, 32'd0, 32'd1,
			64'h3f800000, 1'b1, 32'd0, ST_FQUANT});
		dir_tab.push_back('{TYPE_INT8, 32'd8, 1'b0, 32'h3f800000, 32'd0, 32'd0,
			64'd5, 1'b1, 32'd0, ST_BADQ});
		dir_tab.push_back('{TYPE_INT32, 32'd8, 1'b1, 32'hbf800000, 32'd0, 32'd0,
			64'd5, 1'b1, 32'd0, ST_BADQ});
		dir_tab.push_back('{TYPE_UINT32, 32'd8, 1'b1, 32'h7f800000, 32'd0, 32'd0,
			64'd5, 1'b1, 32'd0, ST_BADQ});
		dir_tab.push_back('{TYPE_INT16, 32'd8, 1'b1, 32'h7fc00000, 32'd0, 32'd0,
			64'd5, 1'b1, 32'd0, ST_BADQ});
		dir_tab.push_back('{TYPE_UINT16, 32'd8, 1'b1, 32'h80000000, 32'd0, 32'd0,
			64'd5, 1'b1, 32'd0, ST_BADQ});
		dir_tab.push_back('{TYPE_INT64, 32'd8, 1'b1, 32'h00000000, 32'd0, 32'd0,
			64'd5, 1'b1, 32'd0, ST_BADQ});
		dir_tab.push_back('{TYPE_UINT64, 32'd8, 1'b1, 32'h7f7fffff, 32'd0, 32'd0,
			64'hffff_ffff_ffff_ffff, 1'b1, 32'd0, ST_NONFIN});
		dir_tab.push_back('{TYPE_FP16, 32'd8, 1'b0, 32'd0, 32'd0, 32'd0,
			64'h7c00, 1'b1, 32'h7f800000, ST_OK});
		dir_tab.push_back('{TYPE_FP16, 32'd8, 1'b0, 32'd0, 32'd0, 32'd3,
			64'h1111_2222_3333_3c00, 1'b1, 32'h3f800000, ST_OK});
		dir_tab.push_back('{TYPE_FP16, 32'd8, 1'b0, 32'd0, 32'd0, 32'd1,
			64'h0001, 1'b0, 32'd0, ST_OK});
		dir_tab.push_back('{TYPE_FP16, 32'd8, 1'b0, 32'd0, 32'd0, 32'd2,
			64'hfe01, 1'b0, 32'd0, ST_OK});
		dir_tab.push_back('{TYPE_FP32, 32'd8, 1'b0, 32'd0, 32'd0, 32'd1,
			64'hdead_beef_7fc1_2345, 1'b1, 32'h7fc12345, ST_OK});
		dir_tab.push_back('{TYPE_INT64, 32'd8, 1'b1, 32'h3f800000, 32'h7fffffff, 32'd0,
			64'h8000_0000_0000_0000, 1'b0, 32'd0, ST_OK});
		dir_tab.push_back('{TYPE_UINT32, 32'd16, 1'b1, 32'h00000001, 32'h80000000, 32'd3,
			64'hffff_ffff, 1'b0, 32'd0, ST_OK});
		dir_tab.push_back('{TYPE_INT32, 32'd4, 1'b1, 32'h00800000, 32'd3, 32'd0,
			64'h0000_0005, 1'b0, 32'd0, ST_OK});
		dir_tab.push_back('{TYPE_UINT8, 32'd4, 1'b1, 32'h3dcccccd, 32'd128, 32'd2,
			64'hffff_ffff_ffff_ff80, 1'b0, 32'd0, ST_OK});

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// registers still at reset: int8 with an empty tensor
		send_elem(32'd0, 64'd0, 1'b1, '{val: 32'd0, st: ST_RANGE});

		foreach (dir_tab[i]) begin
			set_tensor(dir_tab[i].ty, dir_tab[i].nbytes, dir_tab[i].quant,
				dir_tab[i].scale, dir_tab[i].zero);
			send_elem(dir_tab[i].idx, dir_tab[i].raw, dir_tab[i].typed,
				'{val: dir_tab[i].val, st: dir_tab[i].st});
		end

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = idle_tab[ph];
			stall_pct = stall_tab[ph];
			for (int c = 0; c < 9; c++) begin
				random_tensor();
				// long receiver hold-off so the pipe fills and back-pressures the input
				if (ph == 0 && c == 0) hold_req = 1'b1;
				random_elems(24);
			end
		end

		drain();
		if (fail_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
